// ===== sv/b2d_pkg.sv =====
`timescale 1ns / 1ps

package b2d_pkg;

  // bits of one bcd digit and binary bits folded in per conversion cycle
  localparam int unsigned DIGIT_BITS    = 4;
  localparam int unsigned BITS_PER_STEP = 4;

  // ascii code of '0', at the width of the digit_char field
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new value, clear the bcd register
    logic step;   // fold the next four binary bits in by shift-add-3
    logic find;   // locate the leading nonzero digit
    logic emit;   // present the current digit and move to the next one
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;   // the digit pointer sits on the least significant digit
  } dp_sts_t;

endpackage

// ===== sv/binary_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps

// binary to decimal ascii converter. pulse start while busy is low to hand in
// value_i; the digits come back on digit_char_o as ascii '0'..'9', most
// significant first with no leading zeros, one beat per cycle in consecutive
// cycles, each flagged by valid_o for a single cycle. last_digit_o marks the
// units digit, and zero gives a lone '0'. the receiver cannot stall, so every
// beat must be taken in the cycle it shows. the value is folded into bcd four
// bits a cycle by a shift-add-3 unit, then the leading digit is found, then
// the digits are emitted; at 32 bits a value gives 1..10 digits. busy stays
// high from the accept edge and drops in the cycle the last digit shows, so
// the next start can be taken right then. no state carries over between
// values and reset needs no clearing pass.
module binary_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  // digit stream
  output logic                  valid_o,
  output logic [5:0]            digit_char_o,
  output logic                  last_digit_o
);

  import b2d_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: idle, convert, find leading digit, emit digits
  b2d_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // binary and bcd registers, digit pointer and output register
  b2d_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .valid_o      (valid_o),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

// ===== sv/b2d_ctrl.sv =====
`timescale 1ns / 1ps

module b2d_ctrl #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output b2d_pkg::dp_cmd_t  cmd_o,
  input  b2d_pkg::dp_sts_t  sts_i
);

  import b2d_pkg::*;

  localparam int unsigned STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (start) begin
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(STEPS - 1)) begin
            state_q <= ST_FIND;
          end
        end
        ST_FIND: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_q != ST_IDLE);
  assign cmd_o.load = (state_q == ST_IDLE) && start;
  assign cmd_o.step = (state_q == ST_CONV);
  assign cmd_o.find = (state_q == ST_FIND);
  assign cmd_o.emit = (state_q == ST_EMIT);

endmodule

// ===== sv/b2d_dpath.sv =====
`timescale 1ns / 1ps

module b2d_dpath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  b2d_pkg::dp_cmd_t       cmd_i,
  output b2d_pkg::dp_sts_t       sts_o,
  output logic                   valid_o,
  output logic [5:0]             digit_char_o,
  output logic                   last_digit_o
);

  import b2d_pkg::*;

  localparam int unsigned STEPS    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PAD_BITS = STEPS * BITS_PER_STEP;
  // decimal digits of the largest value, floor(bits * log10(2)) + 1
  localparam int unsigned NDIG     = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCD_W    = NDIG * DIGIT_BITS;
  localparam int unsigned IDX_W    = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [PAD_BITS-1:0] bin_q;
  logic [BCD_W-1:0]    bcd_q;
  logic [IDX_W-1:0]    idx_q;
  logic                valid_q;
  logic [5:0]          char_q;
  logic                last_q;

  logic [PAD_BITS-1:0]   bin_d;
  logic [BCD_W-1:0]      bcd_d;
  logic [IDX_W-1:0]      lead;
  logic [DIGIT_BITS-1:0] cur_digit;

  // four shift-add-3 steps per cycle
  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_d[d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
          bcd_d[d*DIGIT_BITS +: DIGIT_BITS] =
            bcd_d[d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[PAD_BITS-1]};
      bin_d = {bin_d[PAD_BITS-2:0], 1'b0};
    end
  end

  // highest nonzero digit, zero gives the units digit
  always_comb begin
    lead = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
        lead = IDX_W'(d);
      end
    end
  end

  assign cur_digit  = bcd_q[{idx_q, 2'b00} +: DIGIT_BITS];
  assign sts_o.last = (idx_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= PAD_BITS'(value_i);
      bcd_q <= '0;
    end else if (cmd_i.step) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
    if (cmd_i.find) begin
      idx_q <= lead;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q - IDX_W'(1);
    end
    if (cmd_i.emit) begin
      char_q <= ASCII_ZERO + {2'b00, cur_digit};
      last_q <= (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign valid_o      = valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

// ===== sv/b2d_checker.sv =====
`timescale 1ns / 1ps

module b2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic [5:0] digit_char_o,
  input logic       last_digit_o
);

  // an accepted command keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // digits of one value leave back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_digit_o |=> valid_o)
    else $error("gap inside a digit stream");

  // only decimal digit codes leave
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (digit_char_o >= 6'd48) && (digit_char_o <= 6'd57))
    else $error("digit code out of range");

  // busy drops exactly when the units digit shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o && last_digit_o)
    else $error("busy dropped without the final digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_digit_o |-> !busy)
    else $error("still busy on the final digit");

endmodule

bind binary_to_decimal_ascii_top b2d_checker u_b2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o)
);

// ===== dv/binary_to_decimal_ascii_top_tb.sv =====
`timescale 1ns / 1ps

// one expected digit beat: ascii code plus units-digit flag
typedef struct packed {
  logic [5:0] digit_char;
  logic       last_digit;
} digit_beat_t;

// keeps the digit beats still owed by the block and checks each one as it shows
class digit_scoreboard;
  localparam int unsigned RADIX = 10;

  digit_beat_t expected_digits_q[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  // split an accepted value into decimal digits, most significant first
  function void push_value(logic [31:0] value);
    logic [3:0]  rev_digits[10];
    logic [31:0] rest;
    int          n;
    int          k;
    digit_beat_t beat;
    rest = value;
    n    = 0;
    // do-while so that zero still gives one digit
    do begin
      rev_digits[n] = 4'(rest % RADIX);
      rest          = rest / RADIX;
      n++;
    end while (rest != 0);
    for (k = n - 1; k >= 0; k--) begin
      beat.digit_char = b2d_pkg::ASCII_ZERO + 6'(rev_digits[k]);
      beat.last_digit = (k == 0);
      expected_digits_q.push_back(beat);
    end
  endfunction

  function void check_digit(logic [5:0] digit_char, logic last_digit);
    digit_beat_t beat;
    if (expected_digits_q.size() == 0) begin
      $error("unexpected digit beat: digit_char %0d, last_digit %0b", digit_char, last_digit);
      errors++;
      return;
    end
    beat = expected_digits_q.pop_front();
    if (digit_char !== beat.digit_char) begin
      $error("digit_char: expected %0d, got %0d", beat.digit_char, digit_char);
      errors++;
    end
    if (last_digit !== beat.last_digit) begin
      $error("last_digit: expected %0b, got %0b", beat.last_digit, last_digit);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_digits_q.size();
  endfunction
endclass

module binary_to_decimal_ascii_top_tb;

  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned RANDOM_ITEMS = 200;
  // longer than the longest item (the fold, the find and 10 digits); a little slack on top
  localparam int unsigned DRAIN_CYCLES = 30;
  // ~218 items, each with its block run plus the longest idle gap, taken many times over
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic                  clk_i;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] value_i = '0;
  logic                  valid_o;
  logic [5:0]            digit_char_o;
  logic                  last_digit_o;

  digit_scoreboard sb = new();

  int unsigned cycle_count = 0;
  // when clear, the sender runs back to back with no idle cycles
  bit          idle_on     = 1'b1;

  // powers of ten, used for the digit-count boundaries
  logic [31:0] pow10[10] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                             32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};

  binary_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung block ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // monitor: everything is sampled at the edge, before the block's own updates land.
  // digit beats are checked first, then a command accepted on the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        sb.check_digit(digit_char_o, last_digit_o);
      end
      if (start && !busy) begin
        sb.push_value(value_i);
      end
    end
  end

  // idle cycles ahead of the next command: mostly none or short, now and then long
  // enough to cover any phase of the fold / find / emit sequence
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 4);
    end else begin
      return $urandom_range(5, 40);
    end
  endfunction

  // random values shaped to spread the digit count evenly and hit the edges
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    case ($urandom_range(0, 4))
      0: return $urandom;
      // random bit length gives every digit count a fair share
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 99);
      // around a power of ten, where the digit count steps
      3: begin
        p = pow10[$urandom_range(0, 9)];
        return p + $urandom_range(0, 2) - 1;
      end
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // hand one value to the block; returns on the edge that accepts it, leaving
  // start high so a back-to-back command needs no drop
  task automatic send_value(input logic [31:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      // junk on the bus while start is low must be ignored
      value_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic [31:0] directed_values[$];
    int unsigned i;
    int unsigned drain;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: zero, single digits, digit-count steps, full scale, bit patterns
    directed_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999,
                        32'd1000000000, 32'd4294967295, 32'd4294967294, 32'd2147483647,
                        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000,
                        32'd1234567890, 32'd0, 32'd7};
    foreach (directed_values[j]) begin
      send_value(directed_values[j]);
    end

    // random part, switching between idling and back-to-back stretches
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
      end
      send_value(pick_value());
    end
    start <= 1'b0;

    // let every owed digit arrive, then watch a while for stray beats
    while (sb.pending() != 0) @(posedge clk_i);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/b2d_pkg.sv
sv/b2d_ctrl.sv
sv/b2d_dpath.sv
sv/binary_to_decimal_ascii_top.sv
sv/b2d_checker.sv
dv/binary_to_decimal_ascii_top_tb.sv
